### rtl/ssmis_pkg.sv
// Shared types, codes and the control program of the independent set round core.
// Used by every module of the block; depends on nothing.
package ssmis_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int IDX_W = 6;
  localparam int ROW_W = 64;
  localparam int MOVES_W = 9;
  localparam int STEP_W = 4;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_ROUND = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [1:0] ST_OUT = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_IN = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SET = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PRIME = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SWEEP1 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SWEEP2 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SWEEP3 = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SWEEP4 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RESULT = 4'd9;

  typedef struct packed {
    logic [1:0] kind;
    logic [IDX_W-1:0] node_index;
    logic [ROW_W-1:0] row_bits;
    logic [1:0] node_state;
    logic deleted;
  } cmd_t;

  typedef struct packed {
    logic [1:0] state_out;
    logic deleted_out;
    logic changed;
    logic stabilized;
    logic [MOVES_W-1:0] round_moves;
  } res_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_TAKE = 3'd1,
    OP_LOAD = 3'd2,
    OP_SET = 3'd3,
    OP_PRIME = 3'd4,
    OP_SWEEP = 3'd5,
    OP_FINISH = 3'd6,
    OP_RESULT = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    RULE_OUT_TO_WAIT = 2'd0,
    RULE_WAIT_TO_OUT = 2'd1,
    RULE_WAIT_TO_IN = 2'd2,
    RULE_IN_TO_OUT = 2'd3
  } rule_t;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_LAST = 2'd2,
    COND_FREE = 2'd3
  } cond_t;

  typedef struct packed {
    op_t op;
    rule_t rule;
    cond_t cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic cmd_valid;
    logic [1:0] kind;
    logic last;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_FETCH: w = '{OP_TAKE, RULE_OUT_TO_WAIT, COND_DISPATCH, STEP_FETCH};
      STEP_LOAD: w = '{OP_LOAD, RULE_OUT_TO_WAIT, COND_ALWAYS, STEP_RESULT};
      STEP_SET: w = '{OP_SET, RULE_OUT_TO_WAIT, COND_ALWAYS, STEP_RESULT};
      STEP_PRIME: w = '{OP_PRIME, RULE_OUT_TO_WAIT, COND_ALWAYS, STEP_SWEEP1};
      STEP_SWEEP1: w = '{OP_SWEEP, RULE_OUT_TO_WAIT, COND_LAST, STEP_SWEEP2};
      STEP_SWEEP2: w = '{OP_SWEEP, RULE_WAIT_TO_OUT, COND_LAST, STEP_SWEEP3};
      STEP_SWEEP3: w = '{OP_SWEEP, RULE_WAIT_TO_IN, COND_LAST, STEP_SWEEP4};
      STEP_SWEEP4: w = '{OP_SWEEP, RULE_IN_TO_OUT, COND_LAST, STEP_FINISH};
      STEP_FINISH: w = '{OP_FINISH, RULE_OUT_TO_WAIT, COND_ALWAYS, STEP_RESULT};
      STEP_RESULT: w = '{OP_RESULT, RULE_OUT_TO_WAIT, COND_FREE, STEP_FETCH};
      default: w = '{OP_NONE, RULE_OUT_TO_WAIT, COND_ALWAYS, STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

### rtl/ssmis_adj_mem.sv
// Adjacency row memory with one write and one registered read port.
// Each row carries a valid bit so that unwritten rows read as zero; uses ssmis_pkg.
module ssmis_adj_mem #(
  parameter int NODE_COUNT = ssmis_pkg::NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  logic [NODE_COUNT-1:0] wr_data,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output logic [NODE_COUNT-1:0] rd_row
);

  logic [NODE_COUNT-1:0] mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] row_valid;
  logic [NODE_COUNT-1:0] rd_data;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_ok <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_ok ? rd_data : '0;

endmodule

### rtl/ssmis_sequencer.sv
// Step counter and jump logic that walks the control program held in ssmis_pkg.
// Drives the control word of the datapath; uses ssmis_pkg.
module ssmis_sequencer (
  input  logic clk,
  input  logic rst,
  input  ssmis_pkg::stat_t stat,
  output ssmis_pkg::ctrl_t ctrl
);

  logic [ssmis_pkg::STEP_W-1:0] pc;
  logic [ssmis_pkg::STEP_W-1:0] pc_next;
  logic [ssmis_pkg::STEP_W-1:0] entry;

  assign ctrl = ssmis_pkg::ucode(pc);

  always_comb begin
    unique case (stat.kind)
      ssmis_pkg::KIND_LOAD: entry = ssmis_pkg::STEP_LOAD;
      ssmis_pkg::KIND_SET: entry = ssmis_pkg::STEP_SET;
      ssmis_pkg::KIND_ROUND: entry = ssmis_pkg::STEP_PRIME;
      ssmis_pkg::KIND_READ: entry = ssmis_pkg::STEP_RESULT;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      ssmis_pkg::COND_ALWAYS: pc_next = ctrl.target;
      ssmis_pkg::COND_DISPATCH: pc_next = stat.cmd_valid ? entry : pc;
      ssmis_pkg::COND_LAST: pc_next = stat.last ? ctrl.target : pc;
      ssmis_pkg::COND_FREE: pc_next = stat.out_free ? ctrl.target : pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ssmis_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/ssmis_datapath.sv
// Node state vectors, rule evaluation, move counter and result register.
// Follows the control word of ssmis_sequencer; uses ssmis_pkg and ssmis_adj_mem.
module ssmis_datapath #(
  parameter int NODE_COUNT = ssmis_pkg::NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  ssmis_pkg::ctrl_t ctrl,
  input  logic cmd_valid,
  input  ssmis_pkg::cmd_t cmd,
  output ssmis_pkg::stat_t stat,
  output logic res_valid,
  input  logic res_ready,
  output ssmis_pkg::res_t res
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int IW = ssmis_pkg::IDX_W;

  logic [1:0] kind_q;
  logic [IW-1:0] idx_q;
  logic [NODE_COUNT-1:0] row_q;
  logic [1:0] st_q;
  logic del_q;

  logic [NODE_COUNT-1:0] in_vec;
  logic [NODE_COUNT-1:0] wait_vec;
  logic [NODE_COUNT-1:0] del_vec;
  logic [AW-1:0] node_i;
  logic [ssmis_pkg::MOVES_W-1:0] moves;
  logic stable_flag;

  logic take;
  logic out_free;
  logic idx_ok;
  logic [AW-1:0] idx_a;
  logic last;
  logic [AW-1:0] next_i;
  logic [AW-1:0] rd_addr;
  logic [NODE_COUNT-1:0] rd_row;
  logic [NODE_COUNT-1:0] one;
  logic [NODE_COUNT-1:0] sel;
  logic [NODE_COUNT-1:0] row;
  logic in_n;
  logic wait_low;
  logic cur_in;
  logic cur_wait;
  logic move;
  logic new_in;
  logic new_wait;

  assign take = (ctrl.op == ssmis_pkg::OP_TAKE) && cmd_valid;
  assign out_free = !res_valid || res_ready;
  assign idx_ok = {1'b0, idx_q} < (IW + 1)'(NODE_COUNT);
  assign idx_a = idx_q[AW-1:0];
  assign last = node_i == AW'(NODE_COUNT - 1);
  assign next_i = last ? '0 : node_i + AW'(1);
  assign rd_addr = (ctrl.op == ssmis_pkg::OP_SWEEP) ? next_i : '0;

  assign stat = '{cmd_valid: cmd_valid, kind: cmd.kind, last: last, out_free: out_free};

  ssmis_adj_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_adj_mem (
    .clk(clk),
    .rst(rst),
    .wr_en((ctrl.op == ssmis_pkg::OP_LOAD) && idx_ok),
    .wr_addr(idx_a),
    .wr_data(row_q),
    .rd_addr(rd_addr),
    .rd_row(rd_row)
  );

  assign one = {{(NODE_COUNT - 1){1'b0}}, 1'b1};
  assign sel = one << node_i;
  assign row = rd_row & ~sel;
  assign in_n = |(row & in_vec & ~del_vec);
  assign wait_low = |(row & (sel - one) & wait_vec & ~del_vec);
  assign cur_in = in_vec[node_i];
  assign cur_wait = wait_vec[node_i];

  always_comb begin
    move = 1'b0;
    new_in = cur_in;
    new_wait = cur_wait;
    case (ctrl.rule)
      ssmis_pkg::RULE_OUT_TO_WAIT: begin
        if (!cur_in && !cur_wait && !in_n) begin
          move = 1'b1;
          new_wait = 1'b1;
        end
      end
      ssmis_pkg::RULE_WAIT_TO_OUT: begin
        if (cur_wait && in_n) begin
          move = 1'b1;
          new_wait = 1'b0;
        end
      end
      ssmis_pkg::RULE_WAIT_TO_IN: begin
        if (cur_wait && !in_n && !wait_low) begin
          move = 1'b1;
          new_wait = 1'b0;
          new_in = 1'b1;
        end
      end
      default: begin
        if (cur_in && in_n) begin
          move = 1'b1;
          new_in = 1'b0;
        end
      end
    endcase
    if (del_vec[node_i]) begin
      move = 1'b0;
      new_in = cur_in;
      new_wait = cur_wait;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_q <= cmd.kind;
      idx_q <= cmd.node_index;
      row_q <= cmd.row_bits[NODE_COUNT-1:0];
      st_q <= cmd.node_state;
      del_q <= cmd.deleted;
    end
    if ((ctrl.op == ssmis_pkg::OP_RESULT) && out_free) begin
      res.deleted_out <= (kind_q == ssmis_pkg::KIND_READ) && idx_ok && del_vec[idx_a];
      res.state_out <= ((kind_q == ssmis_pkg::KIND_READ) && idx_ok) ?
                       {in_vec[idx_a], wait_vec[idx_a]} : ssmis_pkg::ST_OUT;
      res.changed <= (kind_q == ssmis_pkg::KIND_ROUND) && (moves != '0);
      res.stabilized <= stable_flag;
      res.round_moves <= (kind_q == ssmis_pkg::KIND_ROUND) ? moves : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vec <= '0;
      wait_vec <= '0;
      del_vec <= '0;
      node_i <= '0;
      moves <= '0;
      stable_flag <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if ((ctrl.op == ssmis_pkg::OP_SET) && idx_ok && (st_q != ssmis_pkg::ST_BAD)) begin
        in_vec[idx_a] <= st_q == ssmis_pkg::ST_IN;
        wait_vec[idx_a] <= st_q == ssmis_pkg::ST_WAIT;
        del_vec[idx_a] <= del_q;
      end
      if (ctrl.op == ssmis_pkg::OP_PRIME) begin
        node_i <= '0;
        moves <= '0;
      end
      if (ctrl.op == ssmis_pkg::OP_SWEEP) begin
        in_vec[node_i] <= new_in;
        wait_vec[node_i] <= new_wait;
        node_i <= next_i;
        if (move) begin
          moves <= moves + ssmis_pkg::MOVES_W'(1);
        end
      end
      if (ctrl.op == ssmis_pkg::OP_FINISH) begin
        stable_flag <= moves == '0;
      end
      if ((ctrl.op == ssmis_pkg::OP_RESULT) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_states_disjoint: assert property (@(posedge clk) disable iff (rst)
    !(|(in_vec & wait_vec)))
    else $error("A node is held in both the IN and the WAIT state.");

  a_stable_after_round: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == ssmis_pkg::OP_FINISH) |=> (stable_flag == (moves == '0)))
    else $error("The stable flag does not match the moves of the round.");

  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctrl.op == ssmis_pkg::OP_RESULT))
    else $error("A result appeared outside the result step.");

  a_sweep_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == ssmis_pkg::OP_PRIME) |=> (node_i == '0))
    else $error("A sweep did not start at the first node.");
`endif

endmodule

### rtl/self_stabilizing_mis_round_core.sv
// Top level of the self-stabilising maximal independent set round core.
// Joins the control program sequencer and the datapath; uses ssmis_pkg.
//
// Requests arrive on the cmd channel (valid and ready) as ssmis_pkg::cmd_t and
// each gives exactly one result on the res channel as ssmis_pkg::res_t.
// A request loads an adjacency row, sets a node, runs one round or reads a node.
// The core works on one request at a time under a microcoded sequencer.
// A read goes from acceptance straight to its result step; a load or set passes
// through its own step first; the next request is accepted after the result step.
// A round passes through the prime step, four sweeps and the finish step before the
// result step; the four sweeps visit one node per cycle, each set by one registered
// adjacency row read.
// The result sits in an output register, so the next request is accepted
// while the previous result still waits; if the receiver stalls, a second
// result waits in its final step until the register is free.
// Synchronous reset clears all rows, sets every node to OUT and not deleted,
// clears the stable flag and drops any pending result.
module self_stabilizing_mis_round_core #(
  parameter int NODE_COUNT = ssmis_pkg::NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  ssmis_pkg::cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output ssmis_pkg::res_t res
);

  ssmis_pkg::ctrl_t ctrl;
  ssmis_pkg::stat_t stat;

  assign cmd_ready = ctrl.op == ssmis_pkg::OP_TAKE;

  ssmis_sequencer u_sequencer (
    .clk(clk),
    .rst(rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  ssmis_datapath #(
    .NODE_COUNT(NODE_COUNT)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .stat(stat),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

endmodule
